@@ src/ird_pkg.sv @@
package ird_pkg;

    localparam int MAX_BITS_DEF = 32;

    localparam int DUR_W  = 16;
    localparam int TOL_W  = 7;
    localparam int CODE_W = 32;
    localparam int CNT_W  = 6;
    localparam int ADDR_W = 4;
    localparam int APB_W  = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam int HDR_MARK   = 8000;
    localparam int HDR_SPACE  = 4000;
    localparam int BIT_MARK   = 600;
    localparam int ONE_SPACE  = 1600;
    localparam int ZERO_SPACE = 550;

    localparam int VALID_SHORT = 28;
    localparam int VALID_LONG  = 32;

    localparam logic [1:0] REG_TOLERANCE = 2'd0;
    localparam logic [1:0] REG_CODE      = 2'd1;
    localparam logic [1:0] REG_BITS      = 2'd2;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd25;
    localparam logic [CODE_W-1:0] CODE_RESET = 32'd0;
    localparam logic [CNT_W-1:0]  BITS_RESET = 6'd28;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BITS   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic hdr;
        logic one;
        logic zero;
    } pair_class_t;

    typedef struct packed {
        logic [TOL_W-1:0]  tolerance;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  bits;
    } cfg_t;

endpackage

@@ src/ir_pulse_distance_frame_decoder.sv @@
// Path: a pair taken on s_ is held in the input register and classified from it; when a
//   frame ends, its result word loads the result register, which m_ then offers.
// Throughput: one pair per clock while m_ is ready; a result held on m_ stalls the frame
//   logic, and s_ stops while the input register holds a pair that the stalled logic cannot take.
// Reset: aresetn, synchronous, active low; clears frame state and both valid flags
//   and loads the register defaults (tolerance 25, code 0, bits 28).
module ir_pulse_distance_frame_decoder
    import ird_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mark_us[15:0], space_us[31:16]
    input  logic [0:0]           s_tuser,   // first_pair[0]
    input  logic                 s_tlast,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // code_word[31:0], bit_count[37:32], zero[39:38]
    output logic [1:0]           m_tuser,   // frame_valid[0], code_match[1]

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [APB_W-1:0]     pwdata,
    output logic [APB_W-1:0]     prdata,
    output logic                 pready
);

    cfg_t              cfg_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    logic              in_valid_reg;
    logic [DUR_W-1:0]  in_mark_reg;
    logic [DUR_W-1:0]  in_space_reg;
    logic              in_first_reg;
    logic              in_last_reg;
    logic              take;

    pair_class_t       pair_class;
    logic              frame_valid;
    logic [CODE_W-1:0] code_word;
    logic [CNT_W-1:0]  bit_count;
    logic              code_match;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tolerance <= TOL_RESET;
            cfg_reg.code      <= CODE_RESET;
            cfg_reg.bits      <= BITS_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TOLERANCE: cfg_reg.tolerance <= pwdata[TOL_W-1:0];
                REG_CODE:      cfg_reg.code      <= pwdata[CODE_W-1:0];
                REG_BITS:      cfg_reg.bits      <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TOLERANCE: prdata = APB_W'(cfg_reg.tolerance);
            REG_CODE:      prdata = APB_W'(cfg_reg.code);
            REG_BITS:      prdata = APB_W'(cfg_reg.bits);
            default:       prdata = '0;
        endcase
    end

    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mark_reg  <= s_tdata[DUR_W-1:0];
            in_space_reg <= s_tdata[2*DUR_W-1:DUR_W];
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
        end
    end

    ird_window u_window (
        .tolerance  (cfg_reg.tolerance),
        .mark_us    (in_mark_reg),
        .space_us   (in_space_reg),
        .pair_class (pair_class)
    );

    ird_frame #(
        .MAX_BITS (MAX_BITS)
    ) u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .item_first  (in_first_reg),
        .item_last   (in_last_reg),
        .pair_class  (pair_class),
        .cfg         (cfg_reg),
        .item_take   (take),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .frame_valid (frame_valid),
        .code_word   (code_word),
        .bit_count   (bit_count),
        .code_match  (code_match)
    );

    assign m_tdata = {2'b00, bit_count, code_word};
    assign m_tuser = {code_match, frame_valid};

endmodule

@@ src/ird_window.sv @@
module ird_window
    import ird_pkg::*;
(
    input  logic [TOL_W-1:0] tolerance,
    input  logic [DUR_W-1:0] mark_us,
    input  logic [DUR_W-1:0] space_us,
    output pair_class_t      pair_class
);

    localparam int PROD_W = 24;
    localparam int FACT_W = 8;

    logic [FACT_W-1:0] lo_f;
    logic [FACT_W-1:0] hi_f;
    logic [PROD_W-1:0] x_mark;
    logic [PROD_W-1:0] x_space;

    function automatic logic near(
        input logic [PROD_W-1:0] x,
        input logic [PROD_W-1:0] nominal,
        input logic [FACT_W-1:0] lo,
        input logic [FACT_W-1:0] hi
    );
        logic [PROD_W-1:0] lo_b;
        logic [PROD_W-1:0] hi_b;
        lo_b = nominal * PROD_W'(lo);
        hi_b = nominal * PROD_W'(hi);
        return (x >= lo_b) && (x <= hi_b);
    endfunction

    always_comb begin
        lo_f = (tolerance >= TOL_W'(100)) ? '0 : FACT_W'(100) - FACT_W'(tolerance);
        hi_f = FACT_W'(100) + FACT_W'(tolerance);
        x_mark  = PROD_W'(mark_us) * PROD_W'(100);
        x_space = PROD_W'(space_us) * PROD_W'(100);
    end

    assign pair_class.hdr  = near(x_mark, PROD_W'(HDR_MARK), lo_f, hi_f)
                          && near(x_space, PROD_W'(HDR_SPACE), lo_f, hi_f);
    assign pair_class.one  = near(x_mark, PROD_W'(BIT_MARK), lo_f, hi_f)
                          && near(x_space, PROD_W'(ONE_SPACE), lo_f, hi_f);
    assign pair_class.zero = near(x_mark, PROD_W'(BIT_MARK), lo_f, hi_f)
                          && near(x_space, PROD_W'(ZERO_SPACE), lo_f, hi_f);

endmodule

@@ src/ird_frame.sv @@
module ird_frame
    import ird_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  logic              item_first,
    input  logic              item_last,
    input  pair_class_t       pair_class,
    input  cfg_t              cfg,
    output logic              item_take,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              frame_valid,
    output logic [CODE_W-1:0] code_word,
    output logic [CNT_W-1:0]  bit_count,
    output logic              code_match
);

    localparam int CW = ($clog2(MAX_BITS + 1) > CNT_W) ? $clog2(MAX_BITS + 1) : CNT_W;

    phase_t            phase_reg, phase_next, phase_cur;
    logic [CW-1:0]     bits_reg, bits_next;
    logic [CODE_W-1:0] shift_reg, shift_next;
    logic              emit;
    logic              advance;
    logic              fire;

    logic              res_valid_reg, res_valid_next;
    logic              frame_valid_reg, frame_valid_next;
    logic [CODE_W-1:0] code_word_reg;
    logic [CNT_W-1:0]  bit_count_reg;
    logic              code_match_reg, code_match_next;

    assign advance   = !res_valid_reg || res_ready;
    assign fire      = item_valid && advance;
    assign item_take = advance;

    always_comb begin
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        emit       = 1'b0;
        phase_cur  = item_first ? PH_HEADER : phase_reg;
        if (fire) begin
            case (phase_cur)
                PH_HEADER: begin
                    bits_next  = '0;
                    shift_next = '0;
                    if (!pair_class.hdr || item_last) begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_BITS;
                    end
                end
                PH_BITS: begin
                    if (pair_class.one || pair_class.zero) begin
                        shift_next = {shift_reg[CODE_W-2:0], pair_class.one};
                        bits_next  = bits_reg + 1'b1;
                        if (item_last || bits_next >= CW'(MAX_BITS)) begin
                            emit       = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        frame_valid_next = (bits_next == CW'(VALID_SHORT)) || (bits_next == CW'(VALID_LONG));
        code_match_next  = frame_valid_next && (shift_next == cfg.code)
                        && (bits_next == CW'(cfg.bits));
        if (emit) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            bits_reg      <= '0;
            shift_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bits_reg      <= bits_next;
            shift_reg     <= shift_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            frame_valid_reg <= frame_valid_next;
            code_word_reg   <= shift_next;
            bit_count_reg   <= bits_next[CNT_W-1:0];
            code_match_reg  <= code_match_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign frame_valid = frame_valid_reg;
    assign code_word   = code_word_reg;
    assign bit_count   = bit_count_reg;
    assign code_match  = code_match_reg;

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= CW'(MAX_BITS))
        else $error("bit counter beyond frame length");

    a_header_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> bits_reg == '0 && shift_reg == '0)
        else $error("stale bits while waiting for header");

    a_bit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_cur == PH_BITS && !emit |=> bits_reg == CW'($past(bits_reg) + 1'b1))
        else $error("data pair did not advance bit counter");

    a_match_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && code_match_reg |-> frame_valid_reg
            && (bit_count_reg == CNT_W'(VALID_SHORT) || bit_count_reg == CNT_W'(VALID_LONG)))
        else $error("match reported on invalid frame");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ird_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_PAIRS = 150;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [DUR_W-1:0] mark;
        logic [DUR_W-1:0] space;
        logic             first;
        logic             last;
    } pair_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  count;
        logic              match;
    } frame_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_FRAME
    } row_kind_t;

    typedef struct packed {
        pair_t     pair;
        row_kind_t kind;
        frame_t    want;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [APB_W-1:0]     pwdata = '0;
    logic [APB_W-1:0]     prdata;
    logic                 pready;

    ir_pulse_distance_frame_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [TOL_W-1:0]  tol_cfg  = TOL_RESET;
    logic [CODE_W-1:0] code_cfg = CODE_RESET;
    logic [CNT_W-1:0]  bits_cfg = BITS_RESET;
    phase_t            ph       = PH_HEADER;
    int unsigned       nbits    = 0;
    logic [CODE_W-1:0] sreg     = '0;

    frame_t      pending_frames[$];
    row_t        plan[$];
    bit          no_idle = 1'b0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned pairs_sent = 0;
    int unsigned frames_checked = 0;
    int unsigned valid_seen = 0;
    int unsigned match_seen = 0;

    function automatic bit in_window(input logic [DUR_W-1:0] d, input int unsigned nominal);
        longint unsigned lo_f, hi_f, x, n;
        lo_f = (tol_cfg >= 100) ? 0 : 100 - tol_cfg;
        hi_f = 100 + tol_cfg;
        x = d;
        x = x * 100;
        n = nominal;
        return x >= n * lo_f && x <= n * hi_f;
    endfunction

    function automatic frame_t close_frame(input bit hdr_ok);
        frame_t f;
        f.code  = hdr_ok ? sreg : '0;
        f.count = hdr_ok ? CNT_W'(nbits) : '0;
        f.valid = hdr_ok && (nbits == VALID_SHORT || nbits == VALID_LONG);
        f.match = f.valid && f.code == code_cfg && nbits == bits_cfg;
        ph = PH_DONE;
        return f;
    endfunction

    function automatic bit decode_pair(input pair_t p, output frame_t f);
        f = '0;
        if (p.first) begin
            ph = PH_HEADER;
            nbits = 0;
            sreg = '0;
        end
        if (ph == PH_HEADER) begin
            nbits = 0;
            sreg = '0;
            if (!(in_window(p.mark, HDR_MARK) && in_window(p.space, HDR_SPACE))) begin
                f = close_frame(1'b0);
                return 1'b1;
            end
            ph = PH_BITS;
            if (p.last) begin
                f = close_frame(1'b1);
                return 1'b1;
            end
            return 1'b0;
        end
        if (ph != PH_BITS)
            return 1'b0;
        if (in_window(p.mark, BIT_MARK) && in_window(p.space, ONE_SPACE)) begin
            sreg = {sreg[CODE_W-2:0], 1'b1};
        end else if (in_window(p.mark, BIT_MARK) && in_window(p.space, ZERO_SPACE)) begin
            sreg = {sreg[CODE_W-2:0], 1'b0};
        end else begin
            f = close_frame(1'b1);
            return 1'b1;
        end
        nbits++;
        if (p.last || nbits >= MAX_BITS_DEF) begin
            f = close_frame(1'b1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [DUR_W-1:0] jitter(input int unsigned nominal);
        int unsigned t, span, d;
        t = (tol_cfg > 100) ? 100 : tol_cfg;
        span = nominal * t / 100;
        d = $urandom_range(span);
        if ($urandom_range(1))
            d = nominal + d;
        else
            d = nominal - d;
        return d[DUR_W-1:0];
    endfunction

    task automatic send_pair(input pair_t p);
        if (!no_idle && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.space, p.mark};
        s_tuser  <= p.first;
        s_tlast  <= p.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pairs_sent++;
    endtask

    task automatic drive_pair(input pair_t p);
        frame_t f;
        send_pair(p);
        if (decode_pair(p, f))
            pending_frames.push_back(f);
    endtask

    task automatic send_frame();
        pair_t             p;
        int unsigned       n, sel, ending;
        logic [CODE_W-1:0] word;
        logic              bitv;
        if ($urandom_range(99) < 75) begin
            sel = $urandom_range(9);
            n = (sel < 4) ? VALID_SHORT : (sel < 7) ? VALID_LONG : $urandom_range(34);
            word = $urandom_range(1) ? code_cfg : $urandom;
            ending = $urandom_range(99);
            p.mark  = jitter(HDR_MARK);
            p.space = jitter(HDR_SPACE);
            p.first = ($urandom_range(9) != 0);
            p.last  = (ending < 60 && n == 0);
            drive_pair(p);
            for (int j = 0; j < n; j++) begin
                bitv = word[(n - 1 - j) % CODE_W];
                p.mark  = jitter(BIT_MARK);
                p.space = jitter(bitv ? ONE_SPACE : ZERO_SPACE);
                if ($urandom_range(99) < 3) begin
                    p.mark  = $urandom;
                    p.space = $urandom;
                end
                p.first = 1'b0;
                p.last  = (ending < 60 && j == n - 1);
                drive_pair(p);
            end
            if (ending >= 60 && ending < 85) begin
                p.mark  = $urandom;
                p.space = $urandom;
                p.first = 1'b0;
                p.last  = $urandom_range(1);
                drive_pair(p);
            end
        end else begin
            repeat ($urandom_range(4, 1)) begin
                p.mark  = $urandom;
                p.space = $urandom;
                p.first = $urandom_range(1);
                p.last  = $urandom_range(1);
                drive_pair(p);
            end
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [APB_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOLERANCE: tol_cfg  = val[TOL_W-1:0];
            REG_CODE:      code_cfg = val[CODE_W-1:0];
            REG_BITS:      bits_cfg = val[CNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic add_row(input logic [DUR_W-1:0] mark, input logic [DUR_W-1:0] space,
                           input logic first, input logic last, input row_kind_t kind,
                           input logic valid, input logic [CODE_W-1:0] code,
                           input logic [CNT_W-1:0] count, input logic match);
        row_t r;
        r.pair = {mark, space, first, last};
        r.kind = kind;
        r.want = {valid, code, count, match};
        plan.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input logic [CODE_W-1:0] want,
                                 input logic [CODE_W-1:0] got);
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected word: expected none, got %h/%b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                valid_seen += want.valid;
                match_seen += want.match;
                if (m_tuser[0] !== want.valid)
                    note_mismatch("frame_valid", want.valid, m_tuser[0]);
                if (m_tdata[31:0] !== want.code)
                    note_mismatch("code_word", want.code, m_tdata[31:0]);
                if (m_tdata[37:32] !== want.count)
                    note_mismatch("bit_count", want.count, m_tdata[37:32]);
                if (m_tuser[1] !== want.match)
                    note_mismatch("code_match", want.match, m_tuser[1]);
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        pair_t             p;
        frame_t            f;
        bit                got;
        logic [TOL_W-1:0]  t;
        logic [CODE_W-1:0] c;
        logic [CNT_W-1:0]  b;

        add_row(16'd8000,  16'd4000,  1'b0, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd600,   16'd1600,  1'b0, 1'b1, ROW_FRAME,   0, 32'd1, 6'd1, 0);
        add_row(16'hFFFF,  16'hFFFF,  1'b0, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd0,     16'd0,     1'b1, 1'b0, ROW_FRAME,   0, 32'd0, 6'd0, 0);
        add_row(16'd8000,  16'd4000,  1'b1, 1'b1, ROW_FRAME,   0, 32'd0, 6'd0, 0);
        add_row(16'd8000,  16'd4000,  1'b1, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd600,   16'd550,   1'b0, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd600,   16'd1600,  1'b0, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd1000,  16'd1000,  1'b0, 1'b0, ROW_FRAME,   0, 32'd1, 6'd2, 0);
        add_row(16'd6000,  16'd5000,  1'b1, 1'b0, ROW_PREDICT, 0, 32'd0, 6'd0, 0);
        add_row(16'd450,   16'd2000,  1'b0, 1'b0, ROW_PREDICT, 0, 32'd0, 6'd0, 0);
        add_row(16'd750,   16'd413,   1'b0, 1'b0, ROW_PREDICT, 0, 32'd0, 6'd0, 0);
        add_row(16'd751,   16'd550,   1'b0, 1'b0, ROW_PREDICT, 0, 32'd0, 6'd0, 0);
        add_row(16'd5999,  16'd4000,  1'b1, 1'b0, ROW_FRAME,   0, 32'd0, 6'd0, 0);
        add_row(16'd8000,  16'd4000,  1'b0, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd8000,  16'd4000,  1'b1, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd600,   16'd1600,  1'b0, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd8000,  16'd4000,  1'b1, 1'b0, ROW_NONE,    0, 32'd0, 6'd0, 0);
        add_row(16'd600,   16'd550,   1'b0, 1'b1, ROW_FRAME,   0, 32'd0, 6'd1, 0);
        add_row(16'd10000, 16'd5000,  1'b1, 1'b1, ROW_PREDICT, 0, 32'd0, 6'd0, 0);
        add_row(16'd10001, 16'd4000,  1'b1, 1'b0, ROW_PREDICT, 0, 32'd0, 6'd0, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            p = plan[i].pair;
            send_pair(p);
            got = decode_pair(p, f);
            case (plan[i].kind)
                ROW_PREDICT: if (got) pending_frames.push_back(f);
                ROW_FRAME:   pending_frames.push_back(plan[i].want);
                default: ;
            endcase
        end

        for (int k = 0; k < PHASES; k++) begin
            if (k > 0) begin
                drain();
                case (k)
                    1: begin t = 7'd0;   c = 32'hFFFF_FFFF; b = 6'd32; end
                    2: begin t = 7'd100; c = $urandom;      b = 6'd0;  end
                    3: begin t = 7'd127; c = $urandom;      b = 6'd28; end
                    4: begin t = $urandom_range(127); c = $urandom; b = 6'd32; end
                    5: begin t = 7'd10;  c = 32'd0;         b = 6'd28; end
                    6: begin t = $urandom_range(127); c = $urandom; b = $urandom_range(32); end
                    default: begin t = 7'd25; c = $urandom; b = 6'd28; end
                endcase
                reg_write(REG_TOLERANCE, t);
                reg_write(REG_CODE, c);
                reg_write(REG_BITS, b);
            end
            no_idle = (k == 4);
            for (int start = pairs_sent; pairs_sent - start < PHASE_PAIRS; )
                send_frame();
        end

        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d pairs under %0d register settings", pairs_sent, PHASES);
        $display("Checked %0d frames: %0d valid, %0d matching the programmed code",
                 frames_checked, valid_seen, match_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/ird_pkg.sv
src/ird_window.sv
src/ird_frame.sv
src/ir_pulse_distance_frame_decoder.sv
test/tb_top.sv
